// File: sv/serial_frame_receiver_crc16_macros.svh
// Assertion helpers shared by the receiver's RTL files.
`ifndef SERIAL_FRAME_RECEIVER_CRC16_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted
`define SFR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfr assertion failed");
// Checked property, evaluated at every edge including reset
`define SFR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT(label, clk, rst_n, prop)
`define SFR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: sv/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  // Queue depth between front and back
  localparam int unsigned FifoDepthDefault = 2;

  // Frame limits and timer range
  localparam logic [15:0] MaxPayload = 16'd1024;
  localparam logic [17:0] TimeMax    = 18'h3FFFF;

  // CRC-16/CCITT, no reflection, no final xor
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Register reset values
  localparam logic [7:0]  MagicReset     = 8'd0;
  localparam logic [7:0]  VersionReset   = 8'd0;
  localparam logic [10:0] MaxLenReset    = 11'd1024;
  localparam logic [7:0]  MsPerByteReset = 8'd10;

  // Header byte positions
  localparam logic [2:0] HdrPosMagic   = 3'd0;
  localparam logic [2:0] HdrPosVersion = 3'd1;
  localparam logic [2:0] HdrPosLenLo   = 3'd2;
  localparam logic [2:0] HdrPosLenHi   = 3'd3;
  localparam logic [2:0] HdrPosSeqLo   = 3'd4;
  localparam logic [2:0] HdrPosSeqHi   = 3'd5;
  localparam logic [2:0] HdrPosType    = 3'd6;
  localparam logic [2:0] HdrPosOpcode  = 3'd7;

  typedef enum logic [1:0] {
    CfgMagic     = 2'd0,
    CfgVersion   = 2'd1,
    CfgMaxLen    = 2'd2,
    CfgMsPerByte = 2'd3
  } sfr_cfg_idx_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTick = 1'b1
  } sfr_cmd_e;

  typedef enum logic [2:0] {
    KindPayload = 3'd0,
    KindGood    = 3'd1,
    KindReject  = 3'd2,
    KindTimeout = 3'd3,
    KindCrcBad  = 3'd4
  } sfr_kind_e;

  typedef struct packed {
    sfr_cmd_e   cmd;
    logic [7:0] rx_byte;
  } sfr_in_t;

  typedef struct packed {
    sfr_kind_e   kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_opcode;
    logic [15:0] frame_seq;
    logic [10:0] frame_len;
  } sfr_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    sfr_cmd_e   cmd;
    logic       is_magic;
    logic [7:0] rx_byte;
  } sfr_item_t;

  typedef struct packed {
    logic [7:0]  magic_byte;
    logic [7:0]  protocol_version;
    logic [10:0] max_payload_len;
    logic [7:0]  ms_per_payload_byte;
  } sfr_cfg_t;

  // One byte of CRC-16/CCITT, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/sfr_fifo.sv
`default_nettype none
`include "serial_frame_receiver_crc16_macros.svh"

module sfr_fifo import sfr_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire sfr_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output sfr_item_t      item_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sfr_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Guard against overflow and underflow
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `SFR_ASSERT(a_cnt_bound, clk_i, rst_ni, count_q <= CntW'(Depth))
  `SFR_ASSERT(a_cnt_inc, clk_i, rst_ni, (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
  `SFR_ASSERT(a_cnt_dec, clk_i, rst_ni, (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)

endmodule

`default_nettype wire

// File: sv/sfr_front.sv
`default_nettype none

module sfr_front import sfr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire sfr_in_t in_data_i,
  input  wire logic [7:0] magic_byte_i,
  output logic         push_o,
  output sfr_item_t    item_o,
  input  wire logic    full_i
);

  logic      valid_q, valid_d;
  sfr_item_t item_q, item_d;
  logic      take;

  // Hold the item only while the queue is full
  assign in_stall_o = valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign item_o     = item_q;

  // Classify the incoming item
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d          = 1'b1;
      item_d.cmd       = in_data_i.cmd;
      item_d.rx_byte   = in_data_i.rx_byte;
      item_d.is_magic  = (in_data_i.rx_byte == magic_byte_i);
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

// File: sv/sfr_back.sv
`default_nettype none
`include "serial_frame_receiver_crc16_macros.svh"

module sfr_back import sfr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire sfr_cfg_t  cfg_i,
  input  wire logic      item_valid_i,
  input  wire sfr_item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output sfr_out_t       out_data_o
);

  typedef enum logic [1:0] {
    PhMagic   = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2,
    PhCrc     = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [7:0][7:0]  hdr_q, hdr_d;
  logic [10:0]      pcnt_q, pcnt_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       clow_q, clow_d;
  logic             ccnt_q, ccnt_d;
  logic [17:0]      elapsed_q, elapsed_d;
  logic [17:0]      deadline_q, deadline_d;
  logic             out_valid_q, out_valid_d;
  sfr_out_t         out_q, out_d;

  logic             out_ready;
  logic             res_valid;
  sfr_kind_e        res_kind;
  logic [7:0]       res_data;
  logic [9:0]       res_idx;
  logic [15:0]      len_new;
  logic [15:0]      len_cur;
  logic [18:0]      prod;
  logic [7:0]       b;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign pop_o     = item_valid_i && out_ready;
  assign b         = item_i.rx_byte;
  assign len_cur   = {hdr_q[HdrPosLenHi], hdr_q[HdrPosLenLo]};
  assign len_new   = {hdr_d[HdrPosLenHi], hdr_d[HdrPosLenLo]};
  // Accepted lengths never exceed 11 bits
  assign prod      = 19'(len_new[10:0]) * 19'(cfg_i.ms_per_payload_byte);

  // Frame state machine, one item per cycle unless the output stalls
  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    hdr_d      = hdr_q;
    pcnt_d     = pcnt_q;
    crc_d      = crc_q;
    clow_d     = clow_q;
    ccnt_d     = ccnt_q;
    elapsed_d  = elapsed_q;
    deadline_d = deadline_q;
    res_valid  = 1'b0;
    res_kind   = KindPayload;
    res_data   = '0;
    res_idx    = '0;

    if (pop_o) begin
      if (item_i.cmd == CmdTick) begin
        // Saturating millisecond counter
        if (elapsed_q != TimeMax) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end else begin
        unique case (phase_q)
          PhMagic: begin
            if (item_i.is_magic) begin
              hdr_d[HdrPosMagic] = b;
              hcnt_d  = 3'd1;
              crc_d   = crc16_byte(CrcInit, b);
              phase_d = PhHeader;
            end
          end
          PhHeader: begin
            hdr_d[hcnt_q] = b;
            crc_d  = crc16_byte(crc_q, b);
            hcnt_d = hcnt_q + 1'b1;
            if (hcnt_q == HdrPosOpcode) begin
              if (hdr_d[HdrPosMagic] != cfg_i.magic_byte ||
                  hdr_d[HdrPosVersion] != cfg_i.protocol_version ||
                  len_new > {5'd0, cfg_i.max_payload_len} ||
                  len_new > MaxPayload) begin
                phase_d   = PhMagic;
                res_valid = 1'b1;
                res_kind  = KindReject;
              end else begin
                pcnt_d = '0;
                ccnt_d = 1'b0;
                clow_d = '0;
                if (len_new == '0) begin
                  phase_d = PhCrc;
                end else begin
                  deadline_d = (prod > {1'b0, TimeMax}) ? TimeMax : prod[17:0];
                  elapsed_d  = '0;
                  phase_d    = PhPayload;
                end
              end
            end
          end
          PhPayload: begin
            res_valid = 1'b1;
            res_idx   = pcnt_q[9:0];
            if (elapsed_q > deadline_q) begin
              // Late byte is dropped
              phase_d  = PhMagic;
              res_kind = KindTimeout;
            end else begin
              crc_d    = crc16_byte(crc_q, b);
              pcnt_d   = pcnt_q + 1'b1;
              res_kind = KindPayload;
              res_data = b;
              if ({5'd0, pcnt_d} >= len_cur) begin
                ccnt_d  = 1'b0;
                phase_d = PhCrc;
              end
            end
          end
          PhCrc: begin
            if (!ccnt_q) begin
              clow_d = b;
              ccnt_d = 1'b1;
            end else begin
              ccnt_d    = 1'b0;
              phase_d   = PhMagic;
              res_valid = 1'b1;
              res_kind  = ({b, clow_q} == crc_q) ? KindGood : KindCrcBad;
            end
          end
          default: begin
            phase_d = PhMagic;
          end
        endcase
      end
    end

    // Output register, header fields as of this item
    out_valid_d = out_ready ? (pop_o && res_valid) : out_valid_q;
    out_d       = out_q;
    if (pop_o && res_valid) begin
      out_d.kind         = res_kind;
      out_d.data_byte    = res_data;
      out_d.byte_index   = res_idx;
      out_d.frame_type   = hdr_d[HdrPosType];
      out_d.frame_opcode = hdr_d[HdrPosOpcode];
      out_d.frame_seq    = {hdr_d[HdrPosSeqHi], hdr_d[HdrPosSeqLo]};
      out_d.frame_len    = {hdr_d[HdrPosLenHi][2:0], hdr_d[HdrPosLenLo]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMagic;
      hcnt_q      <= '0;
      hdr_q       <= '0;
      pcnt_q      <= '0;
      crc_q       <= CrcInit;
      clow_q      <= '0;
      ccnt_q      <= 1'b0;
      elapsed_q   <= '0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      hcnt_q      <= hcnt_d;
      hdr_q       <= hdr_d;
      pcnt_q      <= pcnt_d;
      crc_q       <= crc_d;
      clow_q      <= clow_d;
      ccnt_q      <= ccnt_d;
      elapsed_q   <= elapsed_d;
      deadline_q  <= deadline_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SFR_ASSERT(a_idx_in_frame, clk_i, rst_ni, (out_valid_q && out_q.kind == KindPayload) |-> ({1'b0, out_q.byte_index} < out_q.frame_len))
  `SFR_ASSERT(a_crc_cnt_phase, clk_i, rst_ni, ccnt_q |-> (phase_q == PhCrc))
  `SFR_ASSERT(a_result_from_pop, clk_i, rst_ni, $rose(out_valid_q) |-> $past(pop_o))

endmodule

`default_nettype wire

// File: sv/serial_frame_receiver_crc16.sv
`default_nettype none
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid / stall  | sfr_in_t  (cmd, rx_byte)
// out     | output    | out_valid / stall | sfr_out_t (kind ... frame_len)
// cfg     | input     | valid / ready     | 2-bit index, 11-bit data
//
// Sustained rate is one item per clock while out_stall_i is low; the back end
// frame FSM updates the CRC for one byte per cycle. After its item transfer, a
// result passes the front register, the queue and the output register; the
// front register loads on the transfer edge itself. Reset is asynchronous and
// active low; no clearing pass is needed. A stalled output holds the back end,
// and the queue absorbs input until full, after which in_stall_o rises.

module serial_frame_receiver_crc16 import sfr_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire sfr_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sfr_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  sfr_cfg_t  cfg_q;
  sfr_item_t push_item, pop_item;
  logic      push, pop, full, empty;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_byte          <= MagicReset;
      cfg_q.protocol_version    <= VersionReset;
      cfg_q.max_payload_len     <= MaxLenReset;
      cfg_q.ms_per_payload_byte <= MsPerByteReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sfr_cfg_idx_e'(cfg_index_i))
        CfgMagic:     cfg_q.magic_byte          <= cfg_data_i[7:0];
        CfgVersion:   cfg_q.protocol_version    <= cfg_data_i[7:0];
        CfgMaxLen:    cfg_q.max_payload_len     <= cfg_data_i;
        CfgMsPerByte: cfg_q.ms_per_payload_byte <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front: input register and classification
  sfr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .magic_byte_i (cfg_q.magic_byte),
    .push_o       (push),
    .item_o       (push_item),
    .full_i       (full)
  );

  // Queue between front and back
  sfr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  // Back: frame state machine and output register
  sfr_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .item_valid_i (!empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

`default_nettype wire
